### rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define AF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define AF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/u8af_pkg.sv
// Types and fold functions for the UTF-8 accent folding stream.
`default_nettype none
package u8af_pkg;

	localparam int unsigned MaxRes = 4;

	// Open-sequence state.
	typedef struct packed {
		logic [1:0] cnt;   // bytes held
		logic [2:0] len;   // expected sequence length
	} state_t;

	// Results of one request, data[0] goes out first.
	typedef struct packed {
		logic [2:0]           count;
		logic [MaxRes-1:0][7:0] data;
	} res_t;

	// Write into the held-byte store.
	typedef struct packed {
		logic       en;
		logic [1:0] idx;
	} hold_wr_t;

	function automatic logic [2:0] seq_len(input logic [7:0] c);
		logic [2:0] n;
		if (c[7] == 1'b0)
			n = 3'd1;
		else if (c[7:5] == 3'b110)
			n = 3'd2;
		else if (c[7:4] == 4'b1110)
			n = 3'd3;
		else if (c[7:3] == 5'b11110)
			n = 3'd4;
		else
			n = 3'd1;
		return n;
	endfunction

	// Latin-1 / Extended-A letter table, 0 = no fold.
	function automatic logic [7:0] latin_letter(input logic [8:0] cp);
		logic [7:0] r;
		unique case (cp)
			9'h0C0, 9'h0C1, 9'h0C2, 9'h0C3, 9'h0C4, 9'h0C5, 9'h0C6,
			9'h0E0, 9'h0E1, 9'h0E2, 9'h0E3, 9'h0E4, 9'h0E5, 9'h0E6,
			9'h100, 9'h101, 9'h102, 9'h103, 9'h104, 9'h105: r = "a";
			9'h0C7, 9'h0E7, 9'h106, 9'h107, 9'h10C, 9'h10D: r = "c";
			9'h0D0, 9'h0F0, 9'h110, 9'h111, 9'h10E, 9'h10F: r = "d";
			9'h0C8, 9'h0C9, 9'h0CA, 9'h0CB, 9'h0E8, 9'h0E9, 9'h0EA, 9'h0EB,
			9'h112, 9'h113, 9'h118, 9'h119, 9'h11A, 9'h11B: r = "e";
			9'h0CC, 9'h0CD, 9'h0CE, 9'h0CF, 9'h0EC, 9'h0ED, 9'h0EE, 9'h0EF,
			9'h128, 9'h129, 9'h12A, 9'h12B, 9'h130, 9'h131: r = "i";
			9'h141, 9'h142: r = "l";
			9'h0D1, 9'h0F1, 9'h143, 9'h144, 9'h147, 9'h148: r = "n";
			9'h0D2, 9'h0D3, 9'h0D4, 9'h0D5, 9'h0D6, 9'h0D8,
			9'h0F2, 9'h0F3, 9'h0F4, 9'h0F5, 9'h0F6, 9'h0F8,
			9'h14C, 9'h14D, 9'h150, 9'h151: r = "o";
			9'h158, 9'h159: r = "r";
			9'h0DF, 9'h15A, 9'h15B, 9'h160, 9'h161, 9'h15E, 9'h15F: r = "s";
			9'h0DE, 9'h0FE, 9'h162, 9'h163, 9'h164, 9'h165: r = "t";
			9'h0D9, 9'h0DA, 9'h0DB, 9'h0DC, 9'h0F9, 9'h0FA, 9'h0FB, 9'h0FC,
			9'h168, 9'h169, 9'h16A, 9'h16B, 9'h16E, 9'h16F: r = "u";
			9'h0DD, 9'h0FD, 9'h0FF, 9'h176, 9'h177, 9'h178: r = "y";
			9'h179, 9'h17A, 9'h17B, 9'h17C, 9'h17D, 9'h17E: r = "z";
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] fold_point(input logic [20:0] cp);
		logic [7:0] r;
		if (cp < 21'h80) begin
			if (cp >= 21'h41 && cp <= 21'h5A)
				r = cp[7:0] + 8'd32;
			else
				r = cp[7:0];
		end else if (cp < 21'h180) begin
			r = latin_letter(cp[8:0]);
		end else begin
			r = 8'h00;
		end
		return r;
	endfunction

	// A single byte taken as its own code point.
	function automatic logic [7:0] fold_alone(input logic [7:0] c);
		logic [7:0] f;
		f = fold_point({13'd0, c});
		return (f != 8'h00) ? f : c;
	endfunction

endpackage
`default_nettype wire

### rtl/u8af_step.sv
// Per-byte decode, fold and fallback logic.
`default_nettype none
module u8af_step (
	input  wire logic [7:0]          c,
	input  wire logic                last,
	input  wire u8af_pkg::state_t    st,
	input  wire logic [2:0][7:0]     pb,
	output u8af_pkg::res_t           res,
	output u8af_pkg::state_t         st_nxt,
	output u8af_pkg::hold_wr_t       wr
);
	import u8af_pkg::*;

	logic        cont;
	logic [2:0]  len;
	logic        fresh_hold;
	logic [7:0]  alone_c;
	logic [7:0]  alone_p0;
	logic [2:0]  n;
	logic [7:0]  b1;
	logic [7:0]  b2;
	logic [20:0] cp;
	logic [7:0]  f;

	assign cont       = (c[7:6] == 2'b10);
	assign len        = seq_len(c);
	assign fresh_hold = (len != 3'd1) && !last;
	assign alone_c    = fold_alone(c);
	assign alone_p0   = fold_alone(pb[0]);
	assign n          = {1'b0, st.cnt} + 3'd1;

	// Sequence bytes with the current byte in the slot after the held ones.
	assign b1 = (st.cnt == 2'd1) ? c : pb[1];
	assign b2 = (st.cnt == 2'd2) ? c : pb[2];

	always_comb begin
		unique case (n)
			3'd2:    cp = {10'd0, pb[0][4:0], c[5:0]};
			3'd3:    cp = {5'd0, pb[0][3:0], b1[5:0], c[5:0]};
			3'd4:    cp = {pb[0][2:0], pb[1][5:0], b2[5:0], c[5:0]};
			default: cp = {13'd0, c};
		endcase
	end

	assign f = fold_point(cp);

	always_comb begin
		res.data  = {c, pb[2], pb[1], pb[0]};
		res.count = 3'd0;
		st_nxt    = st;
		wr.en     = 1'b0;
		wr.idx    = st.cnt;
		if (st.cnt == 2'd0) begin
			res.data[0] = alone_c;
			res.count   = fresh_hold ? 3'd0 : 3'd1;
			st_nxt.cnt  = fresh_hold ? 2'd1 : 2'd0;
			st_nxt.len  = fresh_hold ? len : 3'd0;
			wr.en       = fresh_hold;
		end else if (cont) begin
			res.data[st.cnt] = c;
			if (n >= st.len) begin
				if (f != 8'h00) begin
					res.data[0] = f;
					res.count   = 3'd1;
				end else begin
					res.count   = n;
				end
				st_nxt.cnt = 2'd0;
				st_nxt.len = 3'd0;
			end else if (last) begin
				res.data[0] = alone_p0;
				res.count   = n;
				st_nxt.cnt  = 2'd0;
				st_nxt.len  = 3'd0;
			end else begin
				st_nxt.cnt = n[1:0];
				wr.en      = 1'b1;
			end
		end else begin
			// bad continuation: lead alone, held bytes raw, then restart
			res.data[0]      = alone_p0;
			res.data[st.cnt] = alone_c;
			res.count        = {1'b0, st.cnt} + (fresh_hold ? 3'd0 : 3'd1);
			st_nxt.cnt       = fresh_hold ? 2'd1 : 2'd0;
			st_nxt.len       = fresh_hold ? len : 3'd0;
			wr.en            = fresh_hold;
			wr.idx           = 2'd0;
		end
	end

endmodule
`default_nettype wire

### rtl/utf8_accent_fold_stream_unit.sv
// Top level of the UTF-8 accent folding stream unit.
// Channel | Handshake               | Payload
// text    | text_valid / text_stall | in_byte[7:0], text_end
// fold    | fold_valid / fold_stall | out_byte[7:0], run_end, text_done
//
// Cycles: a request enters the input register, then one pass of decode/fold logic
// loads 0..4 result bytes into the result buffer, which sends one a cycle unless
// fold_stall is high. Without stalls, one-byte requests sustain one request per
// cycle; a longer result holds the input register until its last byte is sent.
// Reset: arst_n clears valids, the buffer count and the open-sequence state.
// Stalls: fold_stall holds the buffer; text_stall rises while the input
// register holds a request that cannot yet move into the buffer.
`default_nettype none
module utf8_accent_fold_stream_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       text_valid,
	output logic            text_stall,
	input  wire logic [7:0] in_byte,
	input  wire logic       text_end,
	output logic            fold_valid,
	input  wire logic       fold_stall,
	output logic [7:0]      out_byte,
	output logic            run_end,
	output logic            text_done
);
	import u8af_pkg::*;

	`include "assert_macros.svh"

	// input register
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        end_s1;

	// open-sequence state; held bytes need no reset, read only after write
	state_t          st_q;
	logic [2:0][7:0] pb_q;

	// result buffer, entry 0 is at the port
	logic [MaxRes-1:0][7:0] buf_q;
	logic [2:0]             buf_cnt_q;
	logic                   buf_end_q;

	res_t     res;
	state_t   st_nxt;
	hold_wr_t wr;
	logic     out_take;
	logic     adv;

	u8af_step u_step (
		.c      (byte_s1),
		.last   (end_s1),
		.st     (st_q),
		.pb     (pb_q),
		.res    (res),
		.st_nxt (st_nxt),
		.wr     (wr)
	);

	assign fold_valid = (buf_cnt_q != 3'd0);
	assign out_take   = fold_valid && !fold_stall;
	// the request moves on once the buffer is empty or sends its last byte now
	assign adv        = valid_s1 && ((buf_cnt_q == 3'd0) || ((buf_cnt_q == 3'd1) && out_take));
	assign text_stall = valid_s1 && !adv;

	assign out_byte  = buf_q[0];
	assign run_end   = (buf_cnt_q == 3'd1);
	assign text_done = buf_end_q && (buf_cnt_q == 3'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= text_stall ? 1'b1 : text_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_valid && !text_stall) begin
			byte_s1 <= in_byte;
			end_s1  <= text_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (adv) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && wr.en) begin
			pb_q[wr.idx] <= byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_cnt_q <= 3'd0;
		end else if (adv && (res.count != 3'd0)) begin
			buf_cnt_q <= res.count;
		end else if (out_take) begin
			buf_cnt_q <= buf_cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && (res.count != 3'd0)) begin
			buf_q     <= res.data;
			buf_end_q <= end_s1;
		end else if (out_take) begin
			buf_q <= {8'h00, buf_q[MaxRes-1:1]};
		end
	end

	`AF_ASSERT_NOW(a_buf_bound, 1'b1, buf_cnt_q <= 3'd4, "result buffer overfull")
	`AF_ASSERT_NOW(a_open_len, st_q.cnt != 2'd0, st_q.len > {1'b0, st_q.cnt},
		"held bytes not below sequence length")
	`AF_ASSERT_NXT(a_end_clears, adv && end_s1, st_q.cnt == 2'd0,
		"sequence left open after end of text")
	`AF_ASSERT_NOW(a_done_last, fold_valid && text_done, run_end,
		"text_done without run_end")

endmodule
`default_nettype wire
